@@ hw/rtl/scs_pkg.sv @@
`default_nettype none
package scs_pkg;

  localparam int MAX_NONZEROS = 256;
  localparam int ADDR_W = $clog2(MAX_NONZEROS);
  localparam int CNT_W = $clog2(MAX_NONZEROS + 1);

  localparam int IDX_W = 32;
  localparam int VAL_W = 16;
  localparam int PROD_W = 2 * VAL_W;
  localparam int DOT_W = 48;
  localparam int SIM_W = 18;
  localparam int FRAC_W = 16;

  // A square is at most 2^30, so the sum of squares needs 31 + CNT_W bits.
  localparam int NORM_W = PROD_W - 1 + CNT_W;
  localparam int SQ_IN_W = NORM_W + FRAC_W;
  localparam int ROOT_W = SQ_IN_W / 2;
  localparam int MUL_W = 2 * ROOT_W;
  localparam int DEN_W = MUL_W - FRAC_W;
  localparam int NUM_W = DOT_W + FRAC_W;

  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_EVAL   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM_RD,
    ST_NORM_ACC,
    ST_MERGE_RD,
    ST_MERGE_CMP,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic init;
    logic norm_acc;
    logic merge_init;
    logic merge_step;
    logic sqrt_start;
    logic mul;
    logic div_start;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic norm_more;
    logic merge_more;
    logic zero;
    logic sqrt_done;
    logic div_done;
  } status_t;

endpackage
`default_nettype wire

@@ hw/rtl/sparse_cosine_similarity.sv @@
`default_nettype none
// Sparse cosine similarity. Loads (command 0 into A, 1 into B) are taken one
// beat per cycle while busy is low; up to 256 elements fit in each store and
// further loads are dropped and reported through truncated. An evaluate
// (command 2) raises busy through a norm pass with a read and an accumulate
// state per element and a merge pass with a read and a compare state per step
// (the store read is registered), a wait on the two square roots run side by
// side, and the loading and running of the bit-serial divider. A zero norm
// skips the roots and the division. The result is shown for one cycle with
// done high and cannot be held off, so the receiver must take it in that
// cycle. Both stores and the truncation flag clear when the result is issued.
module sparse_cosine_similarity (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       command,
  input  wire logic [scs_pkg::IDX_W-1:0]        element_index,
  input  wire logic signed [scs_pkg::VAL_W-1:0] element_value,
  output logic                                  done,
  output logic signed [scs_pkg::SIM_W-1:0]      similarity,
  output logic signed [scs_pkg::DOT_W-1:0]      dot_product,
  output logic                                  zero_norm,
  output logic                                  truncated
);
  import scs_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  scs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .command(command),
    .status(status), .ctrl(ctrl), .busy(busy)
  );

  scs_datapath u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .status(status),
    .element_index(element_index), .element_value(element_value),
    .similarity(similarity), .dot_product(dot_product),
    .zero_norm(zero_norm), .truncated(truncated), .done(done)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result issued while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && command == CMD_EVAL |=> busy)
    else $error("evaluate did not start");
  a_zero_sim: assert property (@(posedge clk) disable iff (rst)
    done && zero_norm |-> similarity == '0)
    else $error("nonzero similarity with zero norm");

endmodule
`default_nettype wire

@@ hw/rtl/scs_sqrt.sv @@
`default_nettype none
module scs_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [scs_pkg::SQ_IN_W-1:0] x,
  output logic      [scs_pkg::ROOT_W-1:0]  root,
  output logic                            done
);
  import scs_pkg::*;

  localparam int CW = $clog2(ROOT_W + 1);

  logic [SQ_IN_W-1:0] xr;
  logic [ROOT_W:0]    rem;
  logic [CW-1:0]      cnt;
  logic               running;
  logic [ROOT_W+2:0]  rem_sh;
  logic [ROOT_W+2:0]  trial;

  // One result bit per cycle: bring down two bits, try subtracting 4r+1.
  assign rem_sh = {rem, xr[SQ_IN_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      running <= 1'b0;
    end else if (start) begin
      running <= 1'b1;
      xr      <= x;
      rem     <= '0;
      root    <= '0;
      cnt     <= CW'(ROOT_W);
    end else if (running) begin
      xr <= {xr[SQ_IN_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= (ROOT_W+1)'(rem_sh - trial);
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= (ROOT_W+1)'(rem_sh);
        root <= {root[ROOT_W-2:0], 1'b0};
      end
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/scs_div.sv @@
`default_nettype none
module scs_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [scs_pkg::NUM_W-1:0]  num,
  input  wire logic [scs_pkg::DEN_W-1:0]  den,
  output logic      [scs_pkg::NUM_W-1:0]  quot,
  output logic                            done
);
  import scs_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] nr;
  logic [DEN_W-1:0] dr;
  logic [DEN_W:0]   rem;
  logic [DEN_W+1:0] rem_sh;
  logic [CW-1:0]    cnt;
  logic             running;

  assign rem_sh = {rem, nr[NUM_W-1]};

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      running <= 1'b0;
    end else if (start) begin
      running <= 1'b1;
      nr      <= num;
      dr      <= den;
      rem     <= '0;
      quot    <= '0;
      cnt     <= CW'(NUM_W);
    end else if (running) begin
      nr <= {nr[NUM_W-2:0], 1'b0};
      if (rem_sh >= {2'b00, dr}) begin
        rem  <= (DEN_W+1)'(rem_sh - {2'b00, dr});
        quot <= {quot[NUM_W-2:0], 1'b1};
      end else begin
        rem  <= (DEN_W+1)'(rem_sh);
        quot <= {quot[NUM_W-2:0], 1'b0};
      end
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/scs_datapath.sv @@
`default_nettype none
module scs_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire scs_pkg::ctrl_t             ctrl,
  output scs_pkg::status_t                status,
  input  wire logic [scs_pkg::IDX_W-1:0]  element_index,
  input  wire logic signed [scs_pkg::VAL_W-1:0] element_value,
  output logic signed [scs_pkg::SIM_W-1:0] similarity,
  output logic signed [scs_pkg::DOT_W-1:0] dot_product,
  output logic                            zero_norm,
  output logic                            truncated,
  output logic                            done
);
  import scs_pkg::*;

  logic [IDX_W+VAL_W-1:0] a_mem [MAX_NONZEROS];
  logic [IDX_W+VAL_W-1:0] b_mem [MAX_NONZEROS];
  logic [IDX_W+VAL_W-1:0] a_q, b_q;

  logic [CNT_W-1:0] a_count, b_count, i, j;
  logic             overflow_seen;
  logic [NORM_W-1:0] na, nb;
  logic signed [DOT_W-1:0] dot;
  logic [MUL_W-1:0] prod;
  logic [ROOT_W-1:0] sa, sb;
  logic sa_done, sb_done, sqrt_seen;
  logic [NUM_W-1:0] quot;
  logic div_done;

  logic [IDX_W-1:0] ia, ib;
  logic signed [VAL_W-1:0] va, vb;
  logic signed [PROD_W-1:0] sq_a, sq_b, ab;
  logic [DOT_W-1:0] mag;
  logic [DEN_W-1:0] den;
  logic zero;
  logic sat;
  logic [SIM_W-1:0] qmag;

  assign ia = a_q[IDX_W+VAL_W-1 -: IDX_W];
  assign ib = b_q[IDX_W+VAL_W-1 -: IDX_W];
  assign va = a_q[VAL_W-1:0];
  assign vb = b_q[VAL_W-1:0];
  assign sq_a = va * va;
  assign sq_b = vb * vb;
  assign ab   = va * vb;

  always_ff @(posedge clk) begin
    if (ctrl.load_a && a_count < CNT_W'(MAX_NONZEROS)) begin
      a_mem[a_count[ADDR_W-1:0]] <= {element_index, element_value};
    end
    if (ctrl.load_b && b_count < CNT_W'(MAX_NONZEROS)) begin
      b_mem[b_count[ADDR_W-1:0]] <= {element_index, element_value};
    end
    a_q <= a_mem[i[ADDR_W-1:0]];
    b_q <= b_mem[j[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_count       <= '0;
      b_count       <= '0;
      overflow_seen <= 1'b0;
    end else if (ctrl.finish) begin
      a_count       <= '0;
      b_count       <= '0;
      overflow_seen <= 1'b0;
    end else if (ctrl.load_a) begin
      if (a_count < CNT_W'(MAX_NONZEROS)) a_count <= a_count + CNT_W'(1);
      else overflow_seen <= 1'b1;
    end else if (ctrl.load_b) begin
      if (b_count < CNT_W'(MAX_NONZEROS)) b_count <= b_count + CNT_W'(1);
      else overflow_seen <= 1'b1;
    end
  end

  // The norm pass walks both stores with i and j kept equal.
  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      i   <= '0;
      j   <= '0;
      na  <= '0;
      nb  <= '0;
      dot <= '0;
    end else if (ctrl.norm_acc) begin
      if (i < a_count) na <= na + NORM_W'(unsigned'(sq_a));
      if (j < b_count) nb <= nb + NORM_W'(unsigned'(sq_b));
      i <= i + CNT_W'(1);
      j <= j + CNT_W'(1);
    end else if (ctrl.merge_init) begin
      i <= '0;
      j <= '0;
    end else if (ctrl.merge_step) begin
      if (ia == ib) begin
        dot <= dot + DOT_W'(ab);
        i   <= i + CNT_W'(1);
        j   <= j + CNT_W'(1);
      end else if (ia < ib) begin
        i <= i + CNT_W'(1);
      end else begin
        j <= j + CNT_W'(1);
      end
    end
  end

  scs_sqrt u_sqrt_a (
    .clk(clk), .rst(rst), .start(ctrl.sqrt_start),
    .x({na, FRAC_W'(0)}), .root(sa), .done(sa_done)
  );
  scs_sqrt u_sqrt_b (
    .clk(clk), .rst(rst), .start(ctrl.sqrt_start),
    .x({nb, FRAC_W'(0)}), .root(sb), .done(sb_done)
  );

  always_ff @(posedge clk) begin
    if (rst || ctrl.sqrt_start) sqrt_seen <= 1'b0;
    else if (sa_done && sb_done) sqrt_seen <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul) prod <= sa * sb;
  end

  assign den = (prod[MUL_W-1:FRAC_W] == '0) ? DEN_W'(1) : prod[MUL_W-1:FRAC_W];
  assign mag = dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);

  scs_div u_div (
    .clk(clk), .rst(rst), .start(ctrl.div_start),
    .num({mag, FRAC_W'(0)}), .den(den), .quot(quot), .done(div_done)
  );

  assign zero = (na == '0) || (nb == '0);
  assign sat  = quot > NUM_W'(65536);
  assign qmag = sat ? SIM_W'(65536) : SIM_W'(quot);

  assign status.norm_more  = (i < a_count) || (j < b_count);
  assign status.merge_more = (i < a_count) && (j < b_count);
  assign status.zero       = zero;
  assign status.sqrt_done  = sqrt_seen;
  assign status.div_done   = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.finish;
    end
    if (ctrl.finish) begin
      dot_product <= dot;
      zero_norm   <= zero;
      truncated   <= overflow_seen;
      if (zero) similarity <= '0;
      else similarity <= dot[DOT_W-1] ? SIM_W'(-qmag) : qmag;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/scs_ctrl.sv @@
`default_nettype none
module scs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [1:0]         command,
  input  wire scs_pkg::status_t   status,
  output scs_pkg::ctrl_t          ctrl,
  output logic                    busy
);
  import scs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (start && command == CMD_EVAL) state_next = ST_NORM_RD;
      ST_NORM_RD:   state_next = status.norm_more ? ST_NORM_ACC : ST_MERGE_RD;
      ST_NORM_ACC:  state_next = ST_NORM_RD;
      ST_MERGE_RD:  state_next = status.merge_more ? ST_MERGE_CMP : ST_SQRT_GO;
      ST_MERGE_CMP: state_next = ST_MERGE_RD;
      ST_SQRT_GO:   state_next = status.zero ? ST_DONE : ST_SQRT_WAIT;
      ST_SQRT_WAIT: if (status.sqrt_done) state_next = ST_MUL;
      ST_MUL:       state_next = ST_DIV_GO;
      ST_DIV_GO:    state_next = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (status.div_done) state_next = ST_DONE;
      ST_DONE:      state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        ctrl.load_a = start && command == CMD_LOAD_A;
        ctrl.load_b = start && command == CMD_LOAD_B;
        ctrl.init   = start && command == CMD_EVAL;
      end
      ST_NORM_RD:   ctrl.merge_init = !status.norm_more;
      ST_NORM_ACC:  ctrl.norm_acc = 1'b1;
      ST_MERGE_CMP: ctrl.merge_step = 1'b1;
      ST_SQRT_GO:   ctrl.sqrt_start = !status.zero;
      ST_MUL:       ctrl.mul = 1'b1;
      ST_DIV_GO:    ctrl.div_start = 1'b1;
      ST_DONE:      ctrl.finish = 1'b1;
      default:      ctrl = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ bench/sparse_cosine_similarity_checker.sv @@
`timescale 1ns / 1ps
module sparse_cosine_similarity_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic [1:0]                        command,
  input  logic [scs_pkg::IDX_W-1:0]         element_index,
  input  logic signed [scs_pkg::VAL_W-1:0]  element_value,
  input  logic                              done,
  input  logic signed [scs_pkg::SIM_W-1:0]  similarity,
  input  logic signed [scs_pkg::DOT_W-1:0]  dot_product,
  input  logic                              zero_norm,
  input  logic                              truncated,
  output int                                fail_count,
  output int                                pending_count,
  output int                                result_count
);
  import scs_pkg::*;

  typedef struct packed {
    logic [SIM_W-1:0] sim;
    logic [DOT_W-1:0] dot;
    logic             zero;
    logic             trunc;
  } cosine_t;

  cosine_t             cosine_q[$];
  logic [IDX_W-1:0]    idx_a[MAX_NONZEROS];
  logic [IDX_W-1:0]    idx_b[MAX_NONZEROS];
  longint              val_a[MAX_NONZEROS];
  longint              val_b[MAX_NONZEROS];
  int                  cnt_a, cnt_b;
  bit                  dropped;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic cosine_t evaluate_pair();
    cosine_t         e;
    longint          dot, sim;
    longint unsigned na, nb, sa, sb, den, mag, q;
    int              i, j;
    dot = 0; na = 0; nb = 0; sim = 0; i = 0; j = 0;
    while (i < cnt_a && j < cnt_b) begin
      if (idx_a[i] == idx_b[j]) begin
        dot += val_a[i] * val_b[j];
        i++; j++;
      end else if (idx_a[i] < idx_b[j]) i++;
      else j++;
    end
    for (i = 0; i < cnt_a; i++) na += val_a[i] * val_a[i];
    for (j = 0; j < cnt_b; j++) nb += val_b[j] * val_b[j];
    e.zero = (na == 0 || nb == 0);
    if (!e.zero) begin
      sa = int_sqrt(na << 16);
      sb = int_sqrt(nb << 16);
      den = (sa * sb) >> 16;
      if (den == 0) den = 1;
      mag = (dot < 0) ? -dot : dot;
      q = (mag << 16) / den;
      if (q > 65536) q = 65536;
      sim = (dot < 0) ? -longint'(q) : longint'(q);
    end
    e.sim = sim[SIM_W-1:0];
    e.dot = dot[DOT_W-1:0];
    e.trunc = dropped;
    return e;
  endfunction

  assign pending_count = cosine_q.size();

  always @(posedge clk) begin
    cosine_t e;
    if (rst) begin
      cnt_a <= 0; cnt_b <= 0; dropped <= 0;
      fail_count <= 0; result_count <= 0;
    end else begin
      if (done) begin
        result_count <= result_count + 1;
        if (cosine_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = cosine_q.pop_front();
          if (similarity !== e.sim || dot_product !== e.dot ||
              zero_norm !== e.zero || truncated !== e.trunc) begin
            fail_count <= fail_count + 1;
            if (similarity !== e.sim)
              $error("similarity: expected %0d, got %0d", $signed(e.sim), similarity);
            if (dot_product !== e.dot)
              $error("dot_product: expected %0d, got %0d", $signed(e.dot), dot_product);
            if (zero_norm !== e.zero)
              $error("zero_norm: expected %0b, got %0b", e.zero, zero_norm);
            if (truncated !== e.trunc)
              $error("truncated: expected %0b, got %0b", e.trunc, truncated);
          end
        end
      end
      if (start && !busy) begin
        case (command)
          CMD_LOAD_A: begin
            if (cnt_a < MAX_NONZEROS) begin
              idx_a[cnt_a] = element_index;
              val_a[cnt_a] = element_value;
              cnt_a = cnt_a + 1;
            end else dropped = 1;
          end
          CMD_LOAD_B: begin
            if (cnt_b < MAX_NONZEROS) begin
              idx_b[cnt_b] = element_index;
              val_b[cnt_b] = element_value;
              cnt_b = cnt_b + 1;
            end else dropped = 1;
          end
          CMD_EVAL: begin
            cosine_q.push_back(evaluate_pair());
            cnt_a = 0; cnt_b = 0; dropped = 0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ bench/sparse_cosine_similarity_tb.sv @@
`timescale 1ns / 1ps
module sparse_cosine_similarity_tb;
  import scs_pkg::*;

  localparam logic [1:0] CMD_IGNORED = 2'd3;

  logic                    clk = 0;
  logic                    rst = 1;
  logic                    start = 0;
  logic [1:0]              command = CMD_LOAD_A;
  logic [IDX_W-1:0]        element_index = '0;
  logic signed [VAL_W-1:0] element_value = '0;
  logic                    busy, done, zero_norm, truncated;
  logic signed [SIM_W-1:0] similarity;
  logic signed [DOT_W-1:0] dot_product;
  int                      fail_count, pending_count, result_count;
  int                      cycle_count = 0;
  int                      idle_pct = 0;
  int                      beat_count = 0;

  localparam int CYCLE_LIMIT = 2000000;

  always #5 clk = ~clk;

  sparse_cosine_similarity u_dut (.*);

  sparse_cosine_similarity_checker u_chk (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** sparse_cosine_similarity: FAILED **");
      $finish;
    end
  end

  // Drives one beat; holds it until the block accepts it. Start stays high
  // into the next call, which lowers it only when it idles.
  task automatic send_beat(logic [1:0] cmd, logic [IDX_W-1:0] idx,
                           logic signed [VAL_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1;
    command <= cmd;
    element_index <= idx;
    element_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    beat_count++;
  endtask

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Loads a vector of n elements. Indices ascend through a small range unless
  // wide is set, so A and B share indices often.
  task automatic load_vector(logic [1:0] cmd, int n, bit wide);
    logic [IDX_W-1:0] idx;
    idx = wide ? $urandom_range(1000) : $urandom_range(3);
    for (int k = 0; k < n; k++) begin
      send_beat(cmd, idx, rand_value());
      idx = wide ? idx + $urandom : idx + $urandom_range(1, 3);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: empty pair, extremes, matching index, full-scale, unordered.
    send_beat(CMD_EVAL, '1, '1);
    send_beat(CMD_LOAD_A, 5, 16'sh7fff);
    send_beat(CMD_EVAL, 0, '0);
    send_beat(CMD_LOAD_A, 32'hffff_ffff, 16'sh8000);
    send_beat(CMD_LOAD_B, 32'hffff_ffff, 16'sh8000);
    send_beat(CMD_EVAL, 0, '0);
    send_beat(CMD_LOAD_A, 0, 16'sh7fff);
    send_beat(CMD_LOAD_B, 0, 16'sh8000);
    send_beat(CMD_LOAD_B, 1, 16'sh0001);
    send_beat(CMD_EVAL, 0, '0);
    send_beat(CMD_LOAD_A, 9, 16'sh0100);
    send_beat(CMD_LOAD_A, 2, 16'sh0100);
    send_beat(CMD_LOAD_B, 2, 16'sh0100);
    send_beat(CMD_LOAD_B, 9, 16'shff00);
    send_beat(CMD_IGNORED, 9, 16'sh0100);
    send_beat(CMD_LOAD_A, 3, '0);
    send_beat(CMD_LOAD_B, 3, '0);
    send_beat(CMD_EVAL, 0, '0);

    // One overfull store to exercise truncation and the largest sum of squares.
    idle_pct = 0;
    for (int k = 0; k <= MAX_NONZEROS; k++) send_beat(CMD_LOAD_A, k, 16'sh8000);
    for (int k = 0; k < 4; k++) send_beat(CMD_LOAD_B, k, 16'sh8000);
    send_beat(CMD_EVAL, 0, '0);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 38 : (phase == 1) ? 56 : 0;
      for (int s = 0; s < 10; s++) begin
        if ($urandom_range(9) == 0) begin
          // Noise: ignored commands and loose loads.
          send_beat(CMD_IGNORED, $urandom, VAL_W'($urandom));
          send_beat(2'($urandom_range(1)), $urandom, VAL_W'($urandom));
        end
        load_vector(CMD_LOAD_A, $urandom_range(8), $urandom_range(3) == 0);
        load_vector(CMD_LOAD_B, $urandom_range(8), $urandom_range(3) == 0);
        send_beat(CMD_EVAL, $urandom, VAL_W'($urandom));
      end
    end
    start <= 0;

    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d beats and checked %0d similarity results across three idle mixes.",
             beat_count, result_count);
    if (fail_count == 0 && pending_count == 0)
      $display("** sparse_cosine_similarity: PASSED **");
    else
      $display("** sparse_cosine_similarity: FAILED **");
    $finish;
  end

endmodule
